// ===== sv/ipfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP flow header extract package
// Shared types and constants for the five-tuple and payload size extractor.
// ----------------------------------------------------------------------------
package ipfe_pkg;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_UNSUPPORTED = 2'd1,
    STATUS_TRUNCATED   = 2'd2,
    STATUS_CLAMPED     = 2'd3
  } status_e;

  typedef struct packed {
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [7:0]  protocol;
    logic [15:0] ip_len;
    logic [3:0]  ip_hdr_words;
    logic [15:0] port_src;
    logic [15:0] port_dst;
    logic [15:0] udp_len;
    logic [3:0]  tcp_hdr_words;
  } frame_t;

  typedef struct packed {
    logic [15:0] byte_pos;
    logic        is_v6;
    logic [7:0]  l4_offset;
  } frame_ctl_t;

  typedef struct packed {
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [7:0]  protocol_out;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] payload_len;
    logic        ipv6_out;
    status_e     status;
  } result_t;

endpackage

// ===== sv/ipfe_byte_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame byte channel
// Valid/ready channel that carries one frame byte per beat with its markers.
// ----------------------------------------------------------------------------
interface ipfe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;
  logic       ipv6_frame;
  logic [7:0] transport_offset;

  modport source (
    output valid, data_byte, first_byte, last_byte, ipv6_frame, transport_offset,
    input  ready
  );

  modport sink (
    input  valid, data_byte, first_byte, last_byte, ipv6_frame, transport_offset,
    output ready
  );
endinterface

// ===== sv/ipfe_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow result channel
// Valid/ready channel that carries one extracted flow record per beat.
// ----------------------------------------------------------------------------
interface ipfe_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] src_addr_hi;
  logic [63:0] src_addr_lo;
  logic [63:0] dst_addr_hi;
  logic [63:0] dst_addr_lo;
  logic [7:0]  protocol_out;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [15:0] payload_len;
  logic        ipv6_out;
  logic [1:0]  status;

  modport source (
    output valid, src_addr_hi, src_addr_lo, dst_addr_hi, dst_addr_lo, protocol_out,
           source_port, dest_port, payload_len, ipv6_out, status,
    input  ready
  );

  modport sink (
    input  valid, src_addr_hi, src_addr_lo, dst_addr_hi, dst_addr_lo, protocol_out,
           source_port, dest_port, payload_len, ipv6_out, status,
    output ready
  );
endinterface

// ===== sv/ipfe_capture.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP flow header extract: field capture
// Tracks the byte position in the frame and captures the IP and transport
// header fields. Presents the fields as they stand after the current byte.
// ----------------------------------------------------------------------------
module ipfe_capture #(
  parameter int unsigned LINK_HEADER_BYTES = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          data_byte_i,
  input  logic                first_byte_i,
  input  logic                last_byte_i,
  input  logic                ipv6_frame_i,
  input  logic [7:0]          transport_offset_i,
  output ipfe_pkg::frame_t    frame_o,
  output ipfe_pkg::frame_ctl_t ctl_o
);

  localparam logic [15:0] LinkBytes = 16'(LINK_HEADER_BYTES);

  logic [15:0]      count_q;
  logic             is_v6_q;
  logic [7:0]       l4_off_q;
  ipfe_pkg::frame_t frame_q;

  logic             is_v6_d;
  logic [7:0]       l4_off_d;
  logic [15:0]      pos;
  logic [15:0]      rel;
  logic [15:0]      l4_rel;
  logic             in_ip;
  logic             in_l4;
  ipfe_pkg::frame_t base;
  ipfe_pkg::frame_t frame_d;

  always_comb begin
    is_v6_d  = first_byte_i ? ipv6_frame_i : is_v6_q;
    l4_off_d = first_byte_i ? transport_offset_i : l4_off_q;
    pos      = first_byte_i ? 16'd0 : count_q;
    base     = first_byte_i ? '0 : frame_q;
    in_ip    = pos >= LinkBytes;
    rel      = pos - LinkBytes;
    in_l4    = in_ip && (rel >= {8'd0, l4_off_d});
    l4_rel   = rel - {8'd0, l4_off_d};
    frame_d  = base;

    if (in_ip) begin
      if (!is_v6_d) begin
        if (rel == 16'd0) begin
          frame_d.ip_hdr_words = data_byte_i[3:0];
        end else if (rel == 16'd2) begin
          frame_d.ip_len[15:8] = data_byte_i;
        end else if (rel == 16'd3) begin
          frame_d.ip_len[7:0] = data_byte_i;
        end else if (rel == 16'd9) begin
          frame_d.protocol = data_byte_i;
        end else if (rel >= 16'd12 && rel <= 16'd15) begin
          frame_d.src_lo = {32'd0, base.src_lo[23:0], data_byte_i};
        end else if (rel >= 16'd16 && rel <= 16'd19) begin
          frame_d.dst_lo = {32'd0, base.dst_lo[23:0], data_byte_i};
        end
      end else begin
        if (rel == 16'd4) begin
          frame_d.ip_len[15:8] = data_byte_i;
        end else if (rel == 16'd5) begin
          frame_d.ip_len[7:0] = data_byte_i;
        end else if (rel == 16'd6) begin
          frame_d.protocol = data_byte_i;
        end else if (rel >= 16'd8 && rel <= 16'd15) begin
          frame_d.src_hi = {base.src_hi[55:0], data_byte_i};
        end else if (rel >= 16'd16 && rel <= 16'd23) begin
          frame_d.src_lo = {base.src_lo[55:0], data_byte_i};
        end else if (rel >= 16'd24 && rel <= 16'd31) begin
          frame_d.dst_hi = {base.dst_hi[55:0], data_byte_i};
        end else if (rel >= 16'd32 && rel <= 16'd39) begin
          frame_d.dst_lo = {base.dst_lo[55:0], data_byte_i};
        end
      end
    end

    if (in_l4) begin
      case (l4_rel)
        16'd0:   frame_d.port_src[15:8] = data_byte_i;
        16'd1:   frame_d.port_src[7:0]  = data_byte_i;
        16'd2:   frame_d.port_dst[15:8] = data_byte_i;
        16'd3:   frame_d.port_dst[7:0]  = data_byte_i;
        16'd4:   frame_d.udp_len[15:8]  = data_byte_i;
        16'd5:   frame_d.udp_len[7:0]   = data_byte_i;
        16'd12:  frame_d.tcp_hdr_words  = data_byte_i[7:4];
        default: ;
      endcase
    end
  end

  assign frame_o = frame_d;
  assign ctl_o   = '{byte_pos: pos, is_v6: is_v6_d, l4_offset: l4_off_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      is_v6_q  <= 1'b0;
      l4_off_q <= '0;
      frame_q  <= '0;
    end else if (step_i) begin
      is_v6_q  <= is_v6_d;
      l4_off_q <= l4_off_d;
      if (last_byte_i) begin
        count_q <= '0;
        frame_q <= '0;
      end else begin
        count_q <= (pos == 16'hFFFF) ? pos : pos + 16'd1;
        frame_q <= frame_d;
      end
    end
  end

endmodule

// ===== sv/ipfe_result_calc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP flow header extract: result calculation
// Checks the frame length and protocol, and works out the payload size and
// status of a finished frame from the captured header fields.
// ----------------------------------------------------------------------------
module ipfe_result_calc #(
  parameter int unsigned LINK_HEADER_BYTES = 14
) (
  input  ipfe_pkg::frame_t     frame_i,
  input  ipfe_pkg::frame_ctl_t ctl_i,
  output ipfe_pkg::result_t    result_o
);

  localparam logic [16:0] LinkBytes = 17'(LINK_HEADER_BYTES);

  logic [16:0] n_bytes;
  logic [16:0] ip_need;
  logic [16:0] l4_need;
  logic        is_tcp;
  logic        is_udp;
  logic [17:0] size;

  always_comb begin
    is_tcp  = frame_i.protocol == ipfe_pkg::PROTO_TCP;
    is_udp  = frame_i.protocol == ipfe_pkg::PROTO_UDP;
    n_bytes = {1'b0, ctl_i.byte_pos} + 17'd1;
    ip_need = LinkBytes + (ctl_i.is_v6 ? 17'd40 : 17'd20);
    l4_need = LinkBytes + {9'd0, ctl_i.l4_offset} + (is_udp ? 17'd6 : 17'd13);

    if (is_udp) begin
      size = {2'd0, frame_i.udp_len} - 18'd8;
    end else begin
      size = {2'd0, frame_i.ip_len} - {12'd0, frame_i.tcp_hdr_words, 2'd0}
           - (ctl_i.is_v6 ? 18'd0 : {12'd0, frame_i.ip_hdr_words, 2'd0});
    end

    result_o.src_addr_hi  = frame_i.src_hi;
    result_o.src_addr_lo  = frame_i.src_lo;
    result_o.dst_addr_hi  = frame_i.dst_hi;
    result_o.dst_addr_lo  = frame_i.dst_lo;
    result_o.protocol_out = frame_i.protocol;
    result_o.ipv6_out     = ctl_i.is_v6;
    result_o.source_port  = '0;
    result_o.dest_port    = '0;
    result_o.payload_len  = '0;

    if (n_bytes < ip_need) begin
      result_o.status = ipfe_pkg::STATUS_TRUNCATED;
    end else if (!is_tcp && !is_udp) begin
      result_o.status = ipfe_pkg::STATUS_UNSUPPORTED;
    end else if (n_bytes < l4_need) begin
      result_o.status = ipfe_pkg::STATUS_TRUNCATED;
    end else begin
      result_o.source_port = frame_i.port_src;
      result_o.dest_port   = frame_i.port_dst;
      if (size[17]) begin
        result_o.status = ipfe_pkg::STATUS_CLAMPED;
      end else begin
        result_o.status      = ipfe_pkg::STATUS_OK;
        result_o.payload_len = size[15:0];
      end
    end
  end

endmodule

// ===== sv/ip_flow_header_extract_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP flow header extract unit
// Extracts the five-tuple and transport payload size of Ethernet frames.
// ----------------------------------------------------------------------------
// Frame bytes enter on byte_i, one byte per beat, with first_byte and
// last_byte marking frame edges. The IP version and the transport offset are
// sampled with the first byte. One flow record leaves on result_o for each
// last byte; other bytes give no beat.
// Each beat lands in an input register and is then processed by the capture
// and calculation logic, whose record is held in an output register. A record
// is valid once it has been loaded into the output register.
// The unit takes one byte per cycle as long as the output register is free or
// is being emptied; that register is the only element that sets the rate.
// When result_o stalls, non-final bytes keep flowing, and a last byte waits
// in the input register until the held record is taken.
// Reset clears the byte position, the captured fields and both valid flags;
// bytes seen before any first byte form an IPv4 frame at transport offset 0.
// ----------------------------------------------------------------------------
module ip_flow_header_extract_unit #(
  parameter int unsigned LINK_HEADER_BYTES = 14
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ipfe_byte_if.sink    byte_i,
  ipfe_result_if.source result_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_first_q;
  logic       in_last_q;
  logic       in_v6_q;
  logic [7:0] in_off_q;

  logic       out_valid_q;
  ipfe_pkg::result_t out_q;

  logic       out_free;
  logic       step;
  logic       in_ready;

  ipfe_pkg::frame_t     frame;
  ipfe_pkg::frame_ctl_t ctl;
  ipfe_pkg::result_t    result_d;

  assign out_free     = !out_valid_q || result_o.ready;
  assign step         = in_valid_q && (!in_last_q || out_free);
  assign in_ready     = !in_valid_q || step;
  assign byte_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && byte_i.valid) begin
      in_byte_q  <= byte_i.data_byte;
      in_first_q <= byte_i.first_byte;
      in_last_q  <= byte_i.last_byte;
      in_v6_q    <= byte_i.ipv6_frame;
      in_off_q   <= byte_i.transport_offset;
    end
  end

  ipfe_capture #(
    .LINK_HEADER_BYTES(LINK_HEADER_BYTES)
  ) u_capture (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (step),
    .data_byte_i        (in_byte_q),
    .first_byte_i       (in_first_q),
    .last_byte_i        (in_last_q),
    .ipv6_frame_i       (in_v6_q),
    .transport_offset_i (in_off_q),
    .frame_o            (frame),
    .ctl_o              (ctl)
  );

  ipfe_result_calc #(
    .LINK_HEADER_BYTES(LINK_HEADER_BYTES)
  ) u_result_calc (
    .frame_i  (frame),
    .ctl_i    (ctl),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_last_q) begin
      out_q <= result_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.src_addr_hi  = out_q.src_addr_hi;
  assign result_o.src_addr_lo  = out_q.src_addr_lo;
  assign result_o.dst_addr_hi  = out_q.dst_addr_hi;
  assign result_o.dst_addr_lo  = out_q.dst_addr_lo;
  assign result_o.protocol_out = out_q.protocol_out;
  assign result_o.source_port  = out_q.source_port;
  assign result_o.dest_port    = out_q.dest_port;
  assign result_o.payload_len  = out_q.payload_len;
  assign result_o.ipv6_out     = out_q.ipv6_out;
  assign result_o.status       = out_q.status;

endmodule
